>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/ffwa_pkg.sv
// Package for the first-fit word allocator: widths, status codes, command types.
// No dependencies.
package ffwa_pkg;
    localparam int unsigned HEAP_WORDS_DEF  = 134217728;
    localparam int unsigned FREE_SLOTS_DEF  = 64;
    localparam int unsigned ALLOC_SLOTS_DEF = 256;
    localparam int unsigned HEAP_BASE_DEF   = 64;
    localparam int unsigned WW = 28;   // word count / start width
    localparam int unsigned OW = 27;   // offset field width
    localparam int unsigned SW = 3;    // status width

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_CAP   = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;        // capture request
        logic scan_clr;    // clear scan results
        logic scan_free;   // examine one free entry (read data valid)
        logic scan_alloc;  // examine one alloc entry
        logic rd_free;     // issue free table read at index
        logic rd_alloc;    // issue alloc table read at index
        logic idx_clr;
        logic idx_inc;
        logic commit_alloc;
        logic commit_rel;
        logic rd_above;    // read free table at found above slot
        logic fault_set;
        logic res_load;
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic       func;
        logic       req_bad;
        logic       idx_last_free;
        logic       idx_last_alloc;
        logic       best_found;
        logic       cap_ok;
        logic       alloc_slot_found;
        logic       free_slot_found;
        logic       match_found;
        logic       above_found;
        logic       below_found;
        logic       off_zero;
    } stat_t;
endpackage

>>> rtl/ffwa_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface ffwa_if #(
    parameter type payload_t = logic
) (
    input logic clk
);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ffwa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ffwa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/ffwa_ctrl.sv
// Allocator sequencer: walks the free and allocation tables and commits.
// Depends on ffwa_pkg.
module ffwa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  logic            enable,
    input  logic            fault,
    input  ffwa_pkg::stat_t st,
    output ffwa_pkg::cmd_t  cmd,
    output logic            busy
);
    import ffwa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ASCAN  = 8'b0000_0010,  // scan alloc table
        S_FSCAN  = 8'b0000_0100,  // scan free table
        S_FLAST  = 8'b0000_1000,  // last free data
        S_DECIDE = 8'b0001_0000,
        S_ABOVE  = 8'b0010_0000,  // read above entry length
        S_MERGE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   alast_reg, alast_next;   // alloc scan has one more read in flight

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        alast_next     = alast_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    cmd.rd_alloc = 1'b1;
                    alast_next   = 1'b0;
                    state_next   = S_ASCAN;
                end
            end
            S_ASCAN:
            begin
                // One entry read per cycle; data of previous index checked here.
                cmd.scan_alloc = 1'b1;
                if (alast_reg)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.rd_free = 1'b1;
                    state_next  = S_FSCAN;
                end
                else
                begin
                    cmd.idx_inc  = 1'b1;
                    cmd.rd_alloc = 1'b1;
                    alast_next   = st.idx_last_alloc;
                end
            end
            S_FSCAN:
            begin
                cmd.scan_free = 1'b1;
                if (st.idx_last_free)
                begin
                    state_next = S_FLAST;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_free = 1'b1;
                end
            end
            S_FLAST:
            begin
                cmd.scan_free = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_DONE;
                if (st.func == FUNC_ALLOC)
                begin
                    if (enable && !fault)
                    begin
                        if (st.req_bad || (!st.best_found && !st.cap_ok)
                            || !st.alloc_slot_found)
                        begin
                            cmd.fault_set = 1'b1;
                        end
                        else
                        begin
                            cmd.commit_alloc = 1'b1;
                        end
                    end
                end
                else if (!st.off_zero && !fault && st.match_found)
                begin
                    if (!st.above_found && !st.below_found && !st.free_slot_found)
                    begin
                        cmd.fault_set = 1'b1;
                    end
                    else if (st.above_found && st.below_found)
                    begin
                        cmd.res_load = 1'b0;
                        cmd.rd_above = 1'b1;
                        state_next   = S_ABOVE;
                    end
                    else
                    begin
                        cmd.commit_rel = 1'b1;
                    end
                end
            end
            S_ABOVE:
            begin
                // keep the above entry on the RAM outputs for the merge
                cmd.rd_above = 1'b1;
                state_next   = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.commit_rel = 1'b1;
                cmd.res_load   = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            alast_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            alast_reg     <= alast_next;
        end
    end
endmodule

>>> rtl/ffwa_dp.sv
// Allocator datapath: table memories, scan trackers, commit writes, result.
// Depends on ffwa_pkg and ffwa_ram.
module ffwa_dp #(
    parameter int unsigned HEAP_WORDS  = ffwa_pkg::HEAP_WORDS_DEF,
    parameter int unsigned FREE_SLOTS  = ffwa_pkg::FREE_SLOTS_DEF,
    parameter int unsigned ALLOC_SLOTS = ffwa_pkg::ALLOC_SLOTS_DEF,
    parameter int unsigned HEAP_BASE   = ffwa_pkg::HEAP_BASE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_func,
    input  logic [ffwa_pkg::WW-1:0]   in_words,
    input  logic [ffwa_pkg::OW-1:0]   in_offset,
    input  ffwa_pkg::cmd_t            cmd,
    output ffwa_pkg::stat_t           st,
    output logic                      fault,
    output logic [ffwa_pkg::OW-1:0]   res_offset,
    output ffwa_pkg::status_t         res_status
);
    import ffwa_pkg::*;

    localparam int unsigned FA = $clog2(FREE_SLOTS);
    localparam int unsigned AA = $clog2(ALLOC_SLOTS);
    localparam int unsigned IW = (FA > AA) ? FA : AA;
    localparam logic [WW:0] HW = (WW+1)'(HEAP_WORDS);

    // Request
    logic          func_reg;
    logic [WW-1:0] req_reg;
    logic [WW-1:0] off_reg;
    logic [WW-1:0] words;
    logic          req_bad;

    // Scan index and the index whose data is on the RAM outputs
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] didx_reg;

    // Valid bits
    logic [FREE_SLOTS-1:0]  fused_reg;
    logic [ALLOC_SLOTS-1:0] aused_reg;

    logic [WW:0]   top_reg;
    logic          fault_reg;

    // Scan results
    logic          best_v_reg;
    logic [FA-1:0] best_reg;
    logic [WW-1:0] best_start_reg, best_len_reg;
    logic          am_v_reg;
    logic [AA-1:0] am_reg;
    logic [WW-1:0] am_len_reg;
    logic          ab_v_reg, be_v_reg;
    logic [FA-1:0] ab_reg, be_reg;
    logic [WW-1:0] ab_len_reg, be_len_reg;

    // RAM ports
    logic          f_we, a_we;
    logic [FA-1:0] f_addr;
    logic [AA-1:0] a_addr;
    logic [WW-1:0] fs_wd, fl_wd, fs_rd, fl_rd, as_rd, al_rd;

    logic [FA-1:0] ffree_slot;
    logic          ffree_v;
    logic [AA-1:0] afree_slot;
    logic          afree_v;

    logic [WW-1:0] rel_end;
    logic [WW-1:0] fend;

    logic [OW-1:0]  res_off_reg;
    status_t        res_st_reg;
    status_t        st_sel;
    logic [OW-1:0]  off_sel;

    assign req_bad = (req_reg == '0) || ({1'b0, req_reg} > HW);
    assign words   = (req_reg + WW'(3)) & ~WW'(3);
    assign rel_end = off_reg + am_len_reg;
    assign fend    = fs_rd + fl_rd;

    // Lowest free slots in valid bits (priority encoders over flag vectors).
    always_comb
    begin
        ffree_slot = '0;
        ffree_v    = 1'b0;
        for (int i = FREE_SLOTS - 1; i >= 0; i--)
        begin
            if (!fused_reg[i])
            begin
                ffree_slot = FA'(i);
                ffree_v    = 1'b1;
            end
        end
        afree_slot = '0;
        afree_v    = 1'b0;
        for (int i = ALLOC_SLOTS - 1; i >= 0; i--)
        begin
            if (!aused_reg[i])
            begin
                afree_slot = AA'(i);
                afree_v    = 1'b1;
            end
        end
    end

    // RAM port control
    always_comb
    begin
        f_we   = 1'b0;
        a_we   = 1'b0;
        f_addr = idx_reg[FA-1:0];
        a_addr = idx_reg[AA-1:0];
        fs_wd  = '0;
        fl_wd  = '0;
        if (cmd.rd_free && !cmd.idx_clr && cmd.idx_inc)
        begin
            f_addr = FA'(idx_reg + IW'(1));
        end
        if (cmd.rd_free && cmd.idx_clr)
        begin
            f_addr = '0;
        end
        if (cmd.rd_alloc && cmd.idx_clr)
        begin
            a_addr = '0;
        end
        else if (cmd.rd_alloc && cmd.idx_inc)
        begin
            a_addr = AA'(idx_reg + IW'(1));
        end
        if (cmd.rd_above)
        begin
            f_addr = ab_reg;
        end
        if (cmd.commit_alloc)
        begin
            a_we   = 1'b1;
            a_addr = afree_slot;
            if (best_v_reg && best_len_reg != words)
            begin
                f_we   = 1'b1;
                f_addr = best_reg;
                fs_wd  = best_start_reg + words;
                fl_wd  = best_len_reg - words;
            end
        end
        if (cmd.commit_rel)
        begin
            f_we = 1'b1;
            if (be_v_reg)
            begin
                // below block keeps its start and grows upward
                f_addr = be_reg;
                fs_wd  = off_reg - be_len_reg;
                fl_wd  = be_len_reg + am_len_reg + (ab_v_reg ? fl_rd : '0);
            end
            else if (ab_v_reg)
            begin
                f_addr = ab_reg;
                fs_wd  = off_reg;
                fl_wd  = ab_len_reg + am_len_reg;
            end
            else
            begin
                f_addr = ffree_slot;
                fs_wd  = off_reg;
                fl_wd  = am_len_reg;
            end
        end
    end

    ffwa_ram #(.WIDTH(WW), .DEPTH(FREE_SLOTS)) u_fs (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(fs_wd), .rdata(fs_rd));
    ffwa_ram #(.WIDTH(WW), .DEPTH(FREE_SLOTS)) u_fl (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(fl_wd), .rdata(fl_rd));
    ffwa_ram #(.WIDTH(WW), .DEPTH(ALLOC_SLOTS)) u_as (
        .clk(clk), .we(a_we), .addr(a_addr),
        .wdata(best_v_reg ? best_start_reg : top_reg[WW-1:0]), .rdata(as_rd));
    ffwa_ram #(.WIDTH(WW), .DEPTH(ALLOC_SLOTS)) u_al (
        .clk(clk), .we(a_we), .addr(a_addr), .wdata(words), .rdata(al_rd));

    // Request capture, index, scans
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            req_reg  <= in_words;
            off_reg  <= {1'b0, in_offset};
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        didx_reg <= cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_reg + IW'(1) : idx_reg);
        if (cmd.scan_clr)
        begin
            best_v_reg <= 1'b0;
            am_v_reg   <= 1'b0;
            ab_v_reg   <= 1'b0;
            be_v_reg   <= 1'b0;
        end
        if (cmd.scan_alloc && !am_v_reg && aused_reg[didx_reg[AA-1:0]]
            && as_rd == off_reg)
        begin
            am_v_reg   <= 1'b1;
            am_reg     <= didx_reg[AA-1:0];
            am_len_reg <= al_rd;
        end
        if (cmd.scan_free && fused_reg[didx_reg[FA-1:0]])
        begin
            if (fl_rd >= words && (!best_v_reg || fs_rd < best_start_reg))
            begin
                best_v_reg     <= 1'b1;
                best_reg       <= didx_reg[FA-1:0];
                best_start_reg <= fs_rd;
                best_len_reg   <= fl_rd;
            end
            if (am_v_reg && !ab_v_reg && fs_rd == rel_end)
            begin
                ab_v_reg   <= 1'b1;
                ab_reg     <= didx_reg[FA-1:0];
                ab_len_reg <= fl_rd;
            end
            if (am_v_reg && !be_v_reg && fend == off_reg)
            begin
                be_v_reg   <= 1'b1;
                be_reg     <= didx_reg[FA-1:0];
                be_len_reg <= off_reg - fs_rd;
            end
        end
    end

    // Control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fused_reg <= '0;
            aused_reg <= '0;
            top_reg   <= (WW+1)'(HEAP_BASE);
            fault_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fault_set)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.commit_alloc)
            begin
                aused_reg[afree_slot] <= 1'b1;
                if (best_v_reg)
                begin
                    if (best_len_reg == words)
                    begin
                        fused_reg[best_reg] <= 1'b0;
                    end
                end
                else
                begin
                    top_reg <= top_reg + {1'b0, words};
                end
            end
            if (cmd.commit_rel)
            begin
                aused_reg[am_reg] <= 1'b0;
                if (be_v_reg)
                begin
                    if (ab_v_reg)
                    begin
                        fused_reg[ab_reg] <= 1'b0;
                    end
                end
                else if (!ab_v_reg)
                begin
                    fused_reg[ffree_slot] <= 1'b1;
                end
            end
        end
    end

    // Result selection
    always_comb
    begin
        off_sel = '0;
        if (func_reg == FUNC_ALLOC)
        begin
            if (!cmd.fault_set && cmd.commit_alloc)
            begin
                st_sel  = ST_OK;
                off_sel = best_v_reg ? best_start_reg[OW-1:0] : top_reg[OW-1:0];
            end
            else if (!cmd.fault_set)
            begin
                st_sel = ST_BLOCKED;
            end
            else if (req_bad)
            begin
                st_sel = ST_BAD_SIZE;
            end
            else if (!best_v_reg && !st.cap_ok)
            begin
                st_sel = ST_NO_CAP;
            end
            else
            begin
                st_sel = ST_FULL;
            end
        end
        else if (off_reg == '0)
        begin
            st_sel = ST_IGNORED;
        end
        else if (fault_reg)
        begin
            st_sel = ST_BLOCKED;
        end
        else if (!am_v_reg)
        begin
            st_sel = ST_IGNORED;
        end
        else if (cmd.fault_set)
        begin
            st_sel = ST_FULL;
        end
        else
        begin
            st_sel = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_off_reg <= off_sel;
            res_st_reg  <= st_sel;
        end
    end

    assign res_offset = res_off_reg;
    assign res_status = res_st_reg;
    assign fault      = fault_reg;

    always_comb
    begin
        st                  = '0;
        st.func             = func_reg;
        st.req_bad          = req_bad;
        st.idx_last_free    = (idx_reg == IW'(FREE_SLOTS - 1));
        st.idx_last_alloc   = (idx_reg + IW'(1) == IW'(ALLOC_SLOTS - 1));
        st.best_found       = best_v_reg;
        st.cap_ok           = (top_reg <= HW) && ({1'b0, words} <= HW - top_reg);
        st.alloc_slot_found = afree_v;
        st.free_slot_found  = ffree_v;
        st.match_found      = am_v_reg;
        st.above_found      = ab_v_reg;
        st.below_found      = be_v_reg;
        st.off_zero         = (off_reg == '0);
    end
endmodule

>>> rtl/first_fit_word_allocator_unit.sv
// Top level of the first-fit word allocator: APB enable register, channels,
// controller and datapath. Depends on ffwa_pkg, ffwa_if, ffwa_ctrl, ffwa_dp.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------
//  req      | in  | func, request_words, release_offset
//  rsp      | out | block_offset, status
//  apb      | in  | enable register at address 0
//
// The response follows a request after the alloc table scan, the free table
// scan, the decision and the done state (above read and merge states are added
// when a release merges on both sides): one alloc table entry then one free
// table entry is read per cycle through the single RAM port of each table.
// Reset clears valid bits at once; no clearing pass. One request at a time;
// a stalled response holds the block until it is taken.
module first_fit_word_allocator_unit #(
    parameter int unsigned HEAP_WORDS  = ffwa_pkg::HEAP_WORDS_DEF,
    parameter int unsigned FREE_SLOTS  = ffwa_pkg::FREE_SLOTS_DEF,
    parameter int unsigned ALLOC_SLOTS = ffwa_pkg::ALLOC_SLOTS_DEF,
    parameter int unsigned HEAP_BASE   = ffwa_pkg::HEAP_BASE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ffwa_if.sink        req,
    ffwa_if.source      rsp
);
    import ffwa_pkg::*;
    `include "assert_macros.svh"

    cmd_t  cmd;
    stat_t st;
    logic  enable_reg;
    logic  fault;
    logic  busy;
    logic  cfg_wr;
    logic [OW-1:0] res_offset;
    status_t       res_status;

    // APB: single register, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {31'd0, enable_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr == 1'b0))
        begin
            enable_reg <= pwdata[0];
        end
    end

    ffwa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .enable(enable_reg), .fault(fault),
        .st(st), .cmd(cmd), .busy(busy));

    ffwa_dp #(
        .HEAP_WORDS(HEAP_WORDS), .FREE_SLOTS(FREE_SLOTS),
        .ALLOC_SLOTS(ALLOC_SLOTS), .HEAP_BASE(HEAP_BASE)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_func(req.data.func), .in_words(req.data.request_words),
        .in_offset(req.data.release_offset),
        .cmd(cmd), .st(st), .fault(fault),
        .res_offset(res_offset), .res_status(res_status));

    assign rsp.data.block_offset = res_offset;
    assign rsp.data.status       = res_status;

    // Never take a request while a response waits.
    `ASSERT_IMPLIES(a_no_accept_pending, clk, rst_n, rsp.valid, !req.ready,
        "request accepted with response pending")
    // Ready only while the sequencer is idle.
    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, req.ready, !busy,
        "request ready while busy")
    // Commit and fault are exclusive.
    `ASSERT_IMPLIES(a_commit_xor_fault, clk, rst_n, cmd.fault_set,
        !cmd.commit_alloc && !cmd.commit_rel, "commit with fault")
    // The fault never clears.
    `ASSERT_NEXT(a_fault_sticky, clk, rst_n, fault, fault, "fault cleared")
    // Any failure reports offset zero.
    `ASSERT_IMPLIES(a_rel_zero_off, clk, rst_n,
        rsp.valid && (rsp.data.status != ST_OK), rsp.data.block_offset == '0,
        "failure with nonzero offset")
endmodule
